### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is high
`define HQME_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising edge, reset included
`define HQME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hqme_pkg.sv
// ----------------------------------------------------------------------------
// hqme_pkg
// Shared constants and types of the heightmap quad mesh emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hqme_pkg;

   // Grid limits
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

   // Field widths
   localparam int CFG_W       = 11;
   localparam int HEIGHT_W    = 16;
   localparam int CODE_W      = 8;
   localparam int COORD_W     = 12;
   localparam int MAT_W       = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;
   localparam int EXT_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_COLUMNS);

   // Terrain codes on the input side
   localparam logic [CODE_W-1:0] TERRAIN_WATER = CODE_W'(0);
   localparam logic [CODE_W-1:0] TERRAIN_SAND  = CODE_W'(1);
   localparam logic [CODE_W-1:0] TERRAIN_GRASS = CODE_W'(2);

   typedef enum logic [MAT_W-1:0] {
      MAT_WATER,
      MAT_SAND,
      MAT_GRASS,
      MAT_SNOW
   } material_type;

   // One cell after the line buffer lookup, ready for vertex emission
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] own;
      logic signed [HEIGHT_W-1:0] left;
      logic signed [HEIGHT_W-1:0] up_mem;
      logic                       col_zero;
      logic                       row_zero;
      logic [COL_W-1:0]           col;
      logic [ROW_W-1:0]           row;
      material_type               mat;
   } cell_type;

   function automatic material_type material_of(input logic [CODE_W-1:0] code);
      material_type m;
      unique case (code)
         TERRAIN_WATER: m = MAT_WATER;
         TERRAIN_SAND:  m = MAT_SAND;
         TERRAIN_GRASS: m = MAT_GRASS;
         default:       m = MAT_SNOW;
      endcase
      return m;
   endfunction

endpackage

### design/hqme_window.sv
// ----------------------------------------------------------------------------
// hqme_window
// Input stage: grid counters, line buffer and left height, one cell register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hqme_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hqme_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hqme_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   output logic                             cell_valid,
   input  logic                             cell_take,
   output hqme_pkg::cell_type               quad
);

   localparam int COL_W    = hqme_pkg::COL_W;
   localparam int ROW_W    = hqme_pkg::ROW_W;
   localparam int EXT_W    = hqme_pkg::EXT_W;
   localparam int HEIGHT_W = hqme_pkg::HEIGHT_W;
   localparam int CODE_W   = hqme_pkg::CODE_W;

   logic [hqme_pkg::CFG_W-1:0]  cols_ff;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic signed [HEIGHT_W-1:0]  left_ff;
   logic                        valid_ff;

   // Line buffer holding the previous row
   logic signed [HEIGHT_W-1:0]  line_mem [hqme_pkg::MAX_COLUMNS];
   logic signed [HEIGHT_W-1:0]  rd_ff;

   // Cell register payload
   logic signed [HEIGHT_W-1:0]  own_ff, lft_ff;
   logic                        col_zero_ff, row_zero_ff;
   logic [COL_W-1:0]            cell_col_ff;
   logic [ROW_W-1:0]            cell_row_ff;
   hqme_pkg::material_type      mat_ff;

   logic                        accept;
   logic signed [HEIGHT_W-1:0]  own;
   logic [CODE_W-1:0]           code;
   logic [EXT_W-1:0]            cols_raw, cols_eff;
   logic [COL_W-1:0]            col_start, col_now;
   logic [ROW_W-1:0]            row_start, row_now;

   function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(hqme_pkg::MAX_ROWS - 1)) ? r : r + ROW_W'(1);
   endfunction

   assign own        = req_tdata[HEIGHT_W-1:0];
   assign code       = req_tdata[HEIGHT_W +: CODE_W];
   assign req_tready = !valid_ff || cell_take;
   assign accept     = req_tvalid && req_tready;

   // Effective column count: zero acts as one, clamp at the buffer size
   always_comb begin
      cols_raw = EXT_W'(cols_ff);
      if (cols_raw == '0) begin
         cols_eff = EXT_W'(1);
      end else if (cols_raw > EXT_W'(hqme_pkg::MAX_COLUMNS)) begin
         cols_eff = EXT_W'(hqme_pkg::MAX_COLUMNS);
      end else begin
         cols_eff = cols_raw;
      end
   end

   // Position of this cell and of the next one
   always_comb begin
      col_start = req_tuser ? '0 : col_ff;
      row_start = req_tuser ? '0 : row_ff;
      if (EXT_W'(col_start) >= cols_eff) begin
         col_now = '0;
         row_now = row_step(row_start);
      end else begin
         col_now = col_start;
         row_now = row_start;
      end
      if (EXT_W'(col_now) + EXT_W'(1) >= cols_eff) begin
         col_in = '0;
         row_in = row_step(row_now);
      end else begin
         col_in = col_now + COL_W'(1);
         row_in = row_now;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= hqme_pkg::COLS_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cols_ff <= csr_wdata;
         end
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            left_ff  <= own;
            valid_ff <= 1'b1;
         end else if (cell_take) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Line buffer: read old entry and write this cell's height at one address
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff             <= line_mem[col_now];
         line_mem[col_now] <= own;
      end
   end

   // Cell payload
   always_ff @(posedge clock) begin
      if (accept) begin
         own_ff      <= own;
         lft_ff      <= (col_now == '0) ? own : left_ff;
         col_zero_ff <= (col_now == '0);
         row_zero_ff <= (row_now == '0);
         cell_col_ff <= col_now;
         cell_row_ff <= row_now;
         mat_ff      <= hqme_pkg::material_of(code);
      end
   end

   assign cell_valid    = valid_ff;
   assign quad.own      = own_ff;
   assign quad.left     = lft_ff;
   assign quad.up_mem   = rd_ff;
   assign quad.col_zero = col_zero_ff;
   assign quad.row_zero = row_zero_ff;
   assign quad.col      = cell_col_ff;
   assign quad.row      = cell_row_ff;
   assign quad.mat      = mat_ff;

endmodule

### design/hqme_vertex.sv
// ----------------------------------------------------------------------------
// hqme_vertex
// Resolves the 2x2 corner window and emits six vertices, one per cycle unless rsp_tready stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hqme_vertex (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cell_valid,
   output logic                             cell_take,
   input  hqme_pkg::cell_type               quad,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hqme_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int HEIGHT_W = hqme_pkg::HEIGHT_W;
   localparam int COORD_W  = hqme_pkg::COORD_W;
   localparam int COL_W    = hqme_pkg::COL_W;
   localparam int ROW_W    = hqme_pkg::ROW_W;
   localparam int PAD_W    = hqme_pkg::RSP_DATA_W
                             - (2 * COORD_W + HEIGHT_W + 2 + hqme_pkg::MAT_W);

   // Vertex order of the two triangles
   typedef enum logic [2:0] {
      V_UPLEFT,
      V_LEFT_A,
      V_UP_A,
      V_OWN,
      V_LEFT_B,
      V_UP_B
   } vertex_type;

   logic                        busy_ff;
   vertex_type                  k_ff;
   logic signed [HEIGHT_W-1:0]  ul_ff, lf_ff, up_ff, own_ff;
   logic signed [HEIGHT_W-1:0]  saved_up_ff;
   logic [COL_W-1:0]            col_ff;
   logic [ROW_W-1:0]            row_ff;
   hqme_pkg::material_type      mat_ff;
   logic                        rsp_valid_ff;
   logic [hqme_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                        rsp_last_ff;

   logic                        load, last_k;
   logic signed [HEIGHT_W-1:0]  up, upleft;
   logic                        xside, zside;
   logic signed [HEIGHT_W-1:0]  vh;
   logic [COORD_W-1:0]          x2, z2, xv, zv;

   // Corner window of the incoming cell
   assign up     = quad.row_zero ? quad.own : quad.up_mem;
   assign upleft = quad.col_zero ? up : saved_up_ff;

   assign load      = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign last_k    = (k_ff == V_UP_B);
   assign cell_take = cell_valid && (!busy_ff || (load && last_k));

   // Corner and side of the current vertex
   always_comb begin
      case (k_ff)
         V_UPLEFT: begin vh = ul_ff;  xside = 1'b0; zside = 1'b0; end
         V_LEFT_A: begin vh = lf_ff;  xside = 1'b0; zside = 1'b1; end
         V_UP_A:   begin vh = up_ff;  xside = 1'b1; zside = 1'b0; end
         V_OWN:    begin vh = own_ff; xside = 1'b1; zside = 1'b1; end
         V_LEFT_B: begin vh = lf_ff;  xside = 1'b0; zside = 1'b1; end
         V_UP_B:   begin vh = up_ff;  xside = 1'b1; zside = 1'b0; end
         default:  begin vh = own_ff; xside = 1'b0; zside = 1'b0; end
      endcase
   end

   // Half-unit coordinates, wrapping at the field width
   assign x2 = COORD_W'({col_ff, 1'b0});
   assign z2 = COORD_W'({row_ff, 1'b0});
   assign xv = xside ? x2 + COORD_W'(1) : x2 - COORD_W'(1);
   assign zv = zside ? z2 + COORD_W'(1) : z2 - COORD_W'(1);

   // Sequencer and output register; a new cell restarts the vertex count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= V_UPLEFT;
         saved_up_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cell_take) begin
            busy_ff     <= 1'b1;
            k_ff        <= V_UPLEFT;
            saved_up_ff <= up;
         end else if (load) begin
            k_ff <= last_k ? V_UPLEFT : vertex_type'(k_ff + 3'd1);
            if (last_k) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Cell payload and vertex payload
   always_ff @(posedge clock) begin
      if (cell_take) begin
         ul_ff  <= upleft;
         lf_ff  <= quad.left;
         up_ff  <= up;
         own_ff <= quad.own;
         col_ff <= quad.col;
         row_ff <= quad.row;
         mat_ff <= quad.mat;
      end
      if (load) begin
         rsp_data_ff <= {PAD_W'(0), mat_ff, zside, xside, zv, vh, xv};
         rsp_last_ff <= last_k;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### design/heightmap_quad_mesh_emitter_top.sv
// Path: the first vertex of a cell passes the cell register, then the vertex
// payload registers and the rsp output register when the vertex stage is idle.
// Throughput: one cell per six vertices, which leave one per cycle through the
// rsp output register unless rsp_tready stalls it; the next cell waits in the input
// stage meanwhile. Reset clears counters, left height, saved up height and
// handshakes and sets grid_columns to 1024; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// heightmap_quad_mesh_emitter_top
// Turns raster heightmap cells into two triangles (six vertices) each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heightmap_quad_mesh_emitter_top (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration: grid_columns
   input  logic                             csr_we,
   input  logic [hqme_pkg::CFG_W-1:0]       csr_wdata,
   // Cell input
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hqme_pkg::REQ_DATA_W-1:0]  req_tdata,  // height[15:0], terrain_code[23:16]
   input  logic                             req_tuser,  // first_of_grid
   // Vertex output
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hqme_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // x_half[11:0], vertex_height[27:12],
                                                        // z_half[39:28], tex_u[40], tex_v[41],
                                                        // material[43:42], zero[47:44]
   output logic                             rsp_tlast   // last_vertex
);

   logic               cell_valid;
   logic               cell_take;
   hqme_pkg::cell_type quad;

   hqme_window u_window (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cell_valid (cell_valid),
      .cell_take  (cell_take),
      .quad       (quad)
   );

   hqme_vertex u_vertex (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (cell_valid),
      .cell_take  (cell_take),
      .quad       (quad),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The closing vertex is the up corner: u set, v clear
   `HQME_ASSERT(a_last_is_up, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata[40] && !rsp_tdata[41], "last vertex is not the up corner")

   // A waiting cell blocks new input
   `HQME_ASSERT(a_full_stalls, clock, reset, cell_valid && !cell_take |-> !req_tready, "input taken while cell register is full")

   // A waiting cell keeps its contents
   `HQME_ASSERT(a_cell_holds, clock, reset, cell_valid && !cell_take |=> cell_valid && $stable(quad), "waiting cell changed")

   // Cells only leave the input stage when one is there
   `HQME_ASSERT_ALWAYS(a_take_valid, clock, cell_take |-> cell_valid, "cell taken from empty stage")

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heightmap quad mesh emitter. Cells are streamed
// in raster order and the six vertices of each are predicted in the bench and
// compared field by field as they leave the block. The runs cover wide and
// narrow grids, grid restarts, one-column grids and shrunk rows, with random
// stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_W     = hqme_pkg::COORD_W;
   localparam int HEIGHT_W    = hqme_pkg::HEIGHT_W;
   localparam int CODE_W      = hqme_pkg::CODE_W;
   localparam int CFG_W       = hqme_pkg::CFG_W;
   localparam int MAT_W       = hqme_pkg::MAT_W;
   localparam int REQ_DATA_W  = hqme_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = hqme_pkg::RSP_DATA_W;
   localparam int MAX_COLUMNS = hqme_pkg::MAX_COLUMNS;
   localparam int MAX_ROWS    = hqme_pkg::MAX_ROWS;

   localparam int unsigned CYCLE_LIMIT = 50000;
   localparam int unsigned IDLE_PCT    = 35;
   // Vertex corner sides, vertex 0 in bit 0
   localparam logic [5:0] X_SIDE = 6'b101100;
   localparam logic [5:0] Z_SIDE = 6'b011010;

   typedef struct packed {
      logic signed [COORD_W-1:0]  x_half;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [COORD_W-1:0]  z_half;
      logic                       tex_u;
      logic                       tex_v;
      hqme_pkg::material_type     mat;
      logic                       last;
   } vertex_rec_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CFG_W-1:0]        csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // height[15:0], terrain_code[23:16]
   logic                    req_tuser;   // first_of_grid
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // x_half, vertex_height, z_half, tex_u,
                                         // tex_v, material, zero pad
   logic                    rsp_tlast;   // last_vertex

   // Predictor state
   logic [HEIGHT_W-1:0]     prior_row [MAX_COLUMNS];
   bit                      prior_row_set [MAX_COLUMNS];
   logic [HEIGHT_W-1:0]     left_h;
   logic [HEIGHT_W-1:0]     saved_up;
   int unsigned             at_col;
   int unsigned             at_row;
   logic [CFG_W-1:0]        grid_cols;

   vertex_rec_type          pending_vertices [$];
   bit                      steady;
   int unsigned             failures;
   int unsigned             cells_sent;
   int unsigned             vertices_seen;
   int unsigned             cfg_writes;
   int unsigned             cycle_count;

   heightmap_quad_mesh_emitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d vertices still pending", $realtime,
                  pending_vertices.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Vertex sink stalls at random unless in a steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Column count after clamping: 0 acts as 1, oversize acts as MAX_COLUMNS
   function automatic int unsigned effective_cols();
      if (grid_cols == 0)
         return 1;
      if (grid_cols > MAX_COLUMNS)
         return MAX_COLUMNS;
      return grid_cols;
   endfunction

   // Advance the grid state by one cell and queue its six vertices
   function automatic void build_quad(input logic [HEIGHT_W-1:0] own,
                                      input logic [CODE_W-1:0] code,
                                      input logic restart);
      int unsigned             eff;
      int unsigned             col;
      logic [HEIGHT_W-1:0]     up;
      logic [HEIGHT_W-1:0]     left;
      logic [HEIGHT_W-1:0]     corner_ul;
      logic [HEIGHT_W-1:0]     hts [6];
      logic [COORD_W-1:0]      xl, xr, zl, zr;
      hqme_pkg::material_type  mat;
      vertex_rec_type          vx;
      eff = effective_cols();
      if (restart) begin
         at_col = 0;
         at_row = 0;
      end
      // shrunk row: a column past the grid width starts the next row
      if (at_col >= eff) begin
         at_col = 0;
         if (at_row < MAX_ROWS - 1)
            at_row++;
      end
      col = at_col;

      // edge rows and columns repeat the nearest known corner
      up        = (at_row == 0) ? own : prior_row[col];
      left      = (col == 0) ? own : left_h;
      corner_ul = (col == 0) ? up : saved_up;
      prior_row[col]     = own;
      prior_row_set[col] = 1'b1;
      left_h             = own;
      saved_up           = up;

      xl  = COORD_W'(2 * col - 1);
      xr  = COORD_W'(2 * col + 1);
      zl  = COORD_W'(2 * at_row - 1);
      zr  = COORD_W'(2 * at_row + 1);
      mat = (code > hqme_pkg::TERRAIN_GRASS) ? hqme_pkg::MAT_SNOW
                                             : hqme_pkg::material_type'(code[MAT_W-1:0]);
      hts = '{corner_ul, left, up, own, left, up};

      for (int k = 0; k < 6; k++) begin
         vx.x_half = X_SIDE[k] ? xr : xl;
         vx.height = hts[k];
         vx.z_half = Z_SIDE[k] ? zr : zl;
         vx.tex_u  = X_SIDE[k];
         vx.tex_v  = Z_SIDE[k];
         vx.mat    = mat;
         vx.last   = (k == 5);
         pending_vertices = {pending_vertices, vx};
      end

      if (at_col + 1 >= eff) begin
         at_col = 0;
         if (at_row < MAX_ROWS - 1)
            at_row++;
      end else begin
         at_col++;
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: vertex %0d %s mismatch: expected %0d, actual %0d", $realtime,
                  vertices_seen, name, want, got);
      end
   endfunction

   // Vertex checker
   always @(posedge clock) begin : vertex_check
      vertex_rec_type want;
      vertex_rec_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x_half = rsp_tdata[11:0];
         got.height = rsp_tdata[27:12];
         got.z_half = rsp_tdata[39:28];
         got.tex_u  = rsp_tdata[40];
         got.tex_v  = rsp_tdata[41];
         got.mat    = hqme_pkg::material_type'(rsp_tdata[43:42]);
         got.last   = rsp_tlast;
         if (pending_vertices.size() == 0) begin
            failures++;
            $display("%0t: vertex with nothing expected: expected none, actual %h",
                     $realtime, rsp_tdata);
         end else begin
            want = pending_vertices.pop_front();
            check_field("x_half", want.x_half, got.x_half);
            check_field("vertex_height", want.height, got.height);
            check_field("z_half", want.z_half, got.z_half);
            check_field("tex_u", want.tex_u, got.tex_u);
            check_field("tex_v", want.tex_v, got.tex_v);
            check_field("material", want.mat, got.mat);
            check_field("last_vertex", want.last, got.last);
         end
         vertices_seen++;
      end
   end

   // Present one cell, wait for its handshake, then predict it
   task automatic send_cell(input logic signed [HEIGHT_W-1:0] h,
                            input logic [CODE_W-1:0] code, input logic first);
      int unsigned c;
      int unsigned r;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      // never let a cell read a line buffer entry that no row has written
      c = at_col;
      r = at_row;
      if (c >= effective_cols()) begin
         c = 0;
         if (r < MAX_ROWS - 1)
            r++;
      end
      if (r != 0 && !prior_row_set[c])
         first = 1'b1;

      req_tvalid <= 1'b1;
      req_tdata  <= {code, h};
      req_tuser  <= first;
      do
         @(posedge clock);
      while (!req_tready);
      build_quad(h, code, first);
      cells_sent++;
   endtask

   // Let every queued vertex leave, then idle for a margin
   task automatic drain_vertices();
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_columns(input logic [CFG_W-1:0] cols);
      csr_we    <= 1'b1;
      csr_wdata <= cols;
      @(posedge clock);
      csr_we    <= 1'b0;
      grid_cols = cols;
      cfg_writes++;
   endtask

   // Start of a 1024-wide row at the reset width
   task automatic test_wide_row();
      for (int i = 0; i < 40; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom_range(0, 3)), i == 0);
      drain_vertices();
   endtask

   // Height and code extremes on a 3-wide grid, restart in mid row
   task automatic test_edge_cases();
      logic signed [HEIGHT_W-1:0] heights [16];
      logic [CODE_W-1:0]          codes [16];
      heights = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555,
                  16'shAAAA, 16'sh3039, -16'sh3039, 16'sh00FF, 16'sh0100, 16'sh7FFE,
                  -16'sh7FFF, 16'sh4000, -16'sh4001, 16'sh1234};
      codes   = '{hqme_pkg::TERRAIN_WATER, hqme_pkg::TERRAIN_SAND,
                  hqme_pkg::TERRAIN_GRASS, 8'd3, 8'd255, 8'd128,
                  8'd127, hqme_pkg::TERRAIN_WATER, hqme_pkg::TERRAIN_GRASS,
                  hqme_pkg::TERRAIN_SAND, 8'd4, 8'd64,
                  hqme_pkg::TERRAIN_WATER, 8'd254, hqme_pkg::TERRAIN_SAND,
                  hqme_pkg::TERRAIN_GRASS};
      set_columns(11'd3);
      for (int i = 0; i < 16; i++)
         send_cell(heights[i], codes[i], i == 0 || i == 10);
      drain_vertices();
   endtask

   // Column count 0 acts as 1: every cell starts a new row
   task automatic test_single_column();
      set_columns(11'd0);
      for (int i = 0; i < 20; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom), i == 0);
      drain_vertices();
   endtask

   // Oversize column count continues the current row
   task automatic test_oversize_columns();
      set_columns(11'd2047);
      for (int i = 0; i < 5; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom), 1'b0);
      drain_vertices();
   endtask

   // Narrow the grid while the column counter is beyond the new width
   task automatic test_shrunk_row();
      set_columns(11'd8);
      for (int i = 0; i < 6; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom_range(0, 3)), i == 0);
      drain_vertices();
      set_columns(11'd4);
      for (int i = 0; i < 6; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom_range(0, 3)), 1'b0);
      drain_vertices();
      set_columns(11'd1);
      for (int i = 0; i < 3; i++)
         send_cell(HEIGHT_W'($urandom), CODE_W'($urandom_range(0, 3)), 1'b0);
      drain_vertices();
   endtask

   // Random grids, mostly narrow, mostly starting with a restart
   task automatic test_random_grids();
      logic [CFG_W-1:0]           cols;
      logic signed [HEIGHT_W-1:0] h;
      logic [CODE_W-1:0]          code;
      logic                       first;
      for (int p = 0; p < 6; p++) begin
         if ($urandom_range(0, 99) < 80)
            cols = CFG_W'($urandom_range(1, 12));
         else
            cols = CFG_W'($urandom_range(0, 2047));
         set_columns(cols);
         steady = (p == 2);
         for (int i = 0; i < 28; i++) begin
            if (i == 0)
               first = ($urandom_range(0, 99) < 75);
            else
               first = ($urandom_range(0, 99) < 3);
            case ($urandom_range(0, 9))
               0:       h = 16'sh7FFF;
               1:       h = -16'sh8000;
               default: h = HEIGHT_W'($urandom);
            endcase
            code = $urandom_range(0, 1) ? CODE_W'($urandom_range(0, 3)) : CODE_W'($urandom);
            send_cell(h, code, first);
         end
         drain_vertices();
         steady = 1'b0;
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      steady        = 1'b0;
      failures      = 0;
      cells_sent    = 0;
      vertices_seen = 0;
      cfg_writes    = 0;
      cycle_count   = 0;
      left_h        = '0;
      saved_up      = '0;
      at_col        = 0;
      at_row        = 0;
      grid_cols     = hqme_pkg::COLS_RESET;
      foreach (prior_row_set[i])
         prior_row_set[i] = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_wide_row();
      test_edge_cases();
      test_single_column();
      test_oversize_columns();
      test_shrunk_row();
      test_random_grids();
      drain_vertices();

      $display("Sent %0d cells, checked %0d vertices, %0d column-count writes.",
               cells_sent, vertices_seen, cfg_writes);
      $display("Grids of 1 to 1024 columns, restarts, one-column and shrunk rows.");
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
